// File: design/acdp_pkg.sv
package acdp_pkg;

    localparam int MAX_LINE_DEF  = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [31:0] ACC_LIMIT_MUL = 32'd214748364;
    localparam logic [31:0] ACC_LIMIT_ADD = 32'd2147483640;
    localparam logic [47:0] OUT_MAX       = 48'h7FFF_FFFF_FFFF;

    localparam int POS_W   = 6;
    localparam int ACC_W   = 32;
    localparam int MAX_EXP = 18;
    localparam int EXP_W   = $clog2(MAX_EXP + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_SUM,
        ST_FIN
    } t_state;

endpackage

// File: design/ascii_command_decimal_parser_core.sv
// channel | direction | handshake                | payload
// input   | in        | i_in_valid / o_in_stall  | i_rx_byte
// output  | out       | o_out_valid / i_out_stall | o_command_byte, o_order_byte,
//         |           |                          | o_parsed_value, o_end_index,
//         |           |                          | o_line_too_long
// a digit byte passes through limit check and times ten, then limit check and add,
// and skips the add when the first limit check stops it
// a carriage return runs the divide-by-ten unit once per fraction digit (at most 18),
// over ceil((32 + FRAC_BITS) / 8) chunks each: the unit retires 8 quotient bits a cycle
// a held result does not block parsing; a second result waits while the first is stalled
// synchronous active-low reset clears the line state and the output valid
module ascii_command_decimal_parser_core
    import acdp_pkg::*;
#(
    parameter int MAX_LINE  = MAX_LINE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_command_byte,
    output logic [7:0]         o_order_byte,
    output logic signed [47:0] o_parsed_value,
    output logic [5:0]         o_end_index,
    output logic               o_line_too_long
);

    localparam int MAG_W   = ACC_W + FRAC_BITS;
    localparam int NCHUNK  = (MAG_W + 7) / 8;
    localparam int DIV_W   = NCHUNK * 8;
    localparam int CHUNK_W = $clog2(NCHUNK);
    localparam int SUM_RAW = ACC_W + FRAC_BITS + 2;
    localparam int TOT_W   = (SUM_RAW > 49) ? SUM_RAW : 49;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NCHUNK - 1);
    localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(OUT_MAX);
    localparam logic signed [TOT_W-1:0] SAT_LO = -SAT_HI;

    t_state r_state, n_state;

    logic [POS_W-1:0]   r_byte_position;
    logic [7:0]         r_command_hold;
    logic [7:0]         r_order_hold;
    logic               r_negative_seen;
    logic [POS_W-1:0]   r_fraction_start;
    logic [ACC_W-1:0]   r_integer_accum;
    logic [ACC_W-1:0]   r_fraction_accum;
    logic               r_stopped_flag;
    logic [POS_W-1:0]   r_stop_position;
    logic               r_overlong_flag;

    logic               r_sel_frac;
    logic [8:0]         r_digit;
    logic [POS_W-1:0]   r_end;
    logic [EXP_W-1:0]   r_exp;
    logic [CHUNK_W-1:0] r_chunk;
    logic [3:0]         r_rem;
    logic [DIV_W-1:0]   r_div;
    logic signed [TOT_W-1:0] r_total;

    logic               r_out_valid;
    logic [7:0]         r_out_command;
    logic [7:0]         r_out_order;
    logic [47:0]        r_out_value;
    logic [5:0]         r_out_end;
    logic               r_out_long;

    logic               in_fire;
    logic               out_free;
    logic               is_cr;
    logic               frac_ok;
    logic [POS_W-1:0]   end_v;
    logic [POS_W-1:0]   exp_v;
    logic [ACC_W-1:0]   frac_abs;
    logic [DIV_W-1:0]   mag;
    logic [ACC_W-1:0]   acc_cur;
    logic [ACC_W-1:0]   acc_x10;
    logic [ACC_W-1:0]   acc_sum;
    logic               lim_mul;
    logic               lim_add;
    logic [7:0]         q_bits;
    logic [3:0]         rem_next;
    logic signed [TOT_W-1:0] int_part;
    logic signed [TOT_W-1:0] quo_s;
    logic signed [TOT_W-1:0] tot_neg;
    logic signed [TOT_W-1:0] tot_sat;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_cr    = (i_rx_byte == CHAR_CR) && (r_byte_position >= POS_W'(2));
    assign end_v    = r_stopped_flag ? r_stop_position : r_byte_position;
    assign exp_v    = end_v - r_fraction_start;
    assign frac_ok  = (r_fraction_start != '0) && (end_v >= r_fraction_start)
                      && (exp_v <= POS_W'(MAX_EXP));
    assign frac_abs = r_fraction_accum[ACC_W-1] ? (~r_fraction_accum + 1'b1)
                                                : r_fraction_accum;
    assign mag      = DIV_W'(frac_abs) << FRAC_BITS;

    assign acc_cur  = r_sel_frac ? r_fraction_accum : r_integer_accum;
    assign acc_x10  = (acc_cur << 3) + (acc_cur << 1);
    assign acc_sum  = acc_cur + {{(ACC_W-9){r_digit[8]}}, r_digit};
    assign lim_mul  = $signed(acc_cur) >= $signed(ACC_LIMIT_MUL);
    assign lim_add  = $signed(acc_cur) >= $signed(ACC_LIMIT_ADD);

    // divide by ten, eight quotient bits per cycle
    always_comb begin
        logic [3:0] rem;
        logic [4:0] t;
        rem = r_rem;
        q_bits = '0;
        for (int i = 0; i < 8; i++) begin
            t = {rem, r_div[DIV_W-1-i]};
            if (t >= 5'd10) begin
                q_bits[7-i] = 1'b1;
                t = t - 5'd10;
            end
            rem = t[3:0];
        end
        rem_next = rem;
    end

    assign int_part = $signed({{(TOT_W-ACC_W){r_integer_accum[ACC_W-1]}}, r_integer_accum})
                      <<< FRAC_BITS;
    assign quo_s    = r_fraction_accum[ACC_W-1]
                      ? -$signed(TOT_W'(r_div[MAG_W-1:0]))
                      :  $signed(TOT_W'(r_div[MAG_W-1:0]));
    assign tot_neg  = r_negative_seen ? -r_total : r_total;
    assign tot_sat  = (tot_neg > SAT_HI) ? SAT_HI : ((tot_neg < SAT_LO) ? SAT_LO : tot_neg);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_cr) begin
                        n_state = (frac_ok && exp_v != '0) ? ST_DIV : ST_SUM;
                    end else if (r_byte_position < MAX_POS
                                 && r_byte_position >= POS_W'(2) && !r_stopped_flag
                                 && i_rx_byte != CHAR_MINUS && i_rx_byte != CHAR_DOT) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_state = lim_mul ? ST_IDLE : ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (r_chunk == LAST_CHUNK && r_exp == EXP_W'(1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position  <= '0;
            r_command_hold   <= '0;
            r_order_hold     <= '0;
            r_negative_seen  <= 1'b0;
            r_fraction_start <= '0;
            r_integer_accum  <= '0;
            r_fraction_accum <= '0;
            r_stopped_flag   <= 1'b0;
            r_stop_position  <= '0;
            r_overlong_flag  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && !is_cr) begin
                        if (r_byte_position >= MAX_POS) begin
                            r_overlong_flag <= 1'b1;
                        end else begin
                            r_byte_position <= r_byte_position + 1'b1;
                            if (r_byte_position == POS_W'(0)) begin
                                r_command_hold <= i_rx_byte;
                            end else if (r_byte_position == POS_W'(1)) begin
                                r_order_hold <= i_rx_byte;
                            end else if (!r_stopped_flag) begin
                                if (i_rx_byte == CHAR_MINUS) begin
                                    r_negative_seen <= 1'b1;
                                end else if (i_rx_byte == CHAR_DOT) begin
                                    r_fraction_start <= r_byte_position + 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_MUL: begin
                    if (lim_mul) begin
                        r_stopped_flag  <= 1'b1;
                        r_stop_position <= r_byte_position - 1'b1;
                    end else if (r_sel_frac) begin
                        r_fraction_accum <= acc_x10;
                    end else begin
                        r_integer_accum <= acc_x10;
                    end
                end
                ST_ADD: begin
                    if (lim_add) begin
                        r_stopped_flag  <= 1'b1;
                        r_stop_position <= r_byte_position - 1'b1;
                    end else if (r_sel_frac) begin
                        r_fraction_accum <= acc_sum;
                    end else begin
                        r_integer_accum <= acc_sum;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_byte_position  <= '0;
                        r_command_hold   <= '0;
                        r_order_hold     <= '0;
                        r_negative_seen  <= 1'b0;
                        r_fraction_start <= '0;
                        r_integer_accum  <= '0;
                        r_fraction_accum <= '0;
                        r_stopped_flag   <= 1'b0;
                        r_stop_position  <= '0;
                        r_overlong_flag  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_sel_frac <= (r_fraction_start != '0);
                r_digit    <= {1'b0, i_rx_byte} - {1'b0, CHAR_ZERO};
                r_end      <= end_v;
                r_exp      <= frac_ok ? exp_v[EXP_W-1:0] : '0;
                r_div      <= frac_ok ? mag : '0;
                r_chunk    <= '0;
                r_rem      <= '0;
            end
            ST_DIV: begin
                r_div <= {r_div[DIV_W-9:0], q_bits};
                if (r_chunk == LAST_CHUNK) begin
                    r_chunk <= '0;
                    r_rem   <= '0;
                    r_exp   <= r_exp - 1'b1;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                    r_rem   <= rem_next;
                end
            end
            ST_SUM: begin
                r_total <= int_part + quo_s;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out_command <= r_command_hold;
            r_out_order   <= r_order_hold;
            r_out_value   <= tot_sat[47:0];
            r_out_end     <= r_end;
            r_out_long    <= r_overlong_flag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_byte  = r_out_command;
    assign o_order_byte    = r_out_order;
    assign o_parsed_value  = $signed(r_out_value);
    assign o_end_index     = r_out_end;
    assign o_line_too_long = r_out_long;

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside finish step");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_position <= MAX_POS)
        else $error("byte position beyond line limit");

    a_div_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_exp != '0)
        else $error("divide loop with no digits left");

    a_stop_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped_flag |-> r_stop_position >= POS_W'(2))
        else $error("stop inside command or order byte");
`endif

endmodule

// File: tb/sv/ascii_command_decimal_parser_checker.sv
`timescale 1ns / 1ps

module ascii_command_decimal_parser_checker
    import acdp_pkg::*;
#(
    parameter int MAX_LINE  = MAX_LINE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_command_byte,
    input  logic [7:0]         i_order_byte,
    input  logic signed [47:0] i_parsed_value,
    input  logic [5:0]         i_end_index,
    input  logic               i_line_too_long,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint VALUE_MAX = longint'({16'd0, OUT_MAX});

    typedef struct packed {
        logic [7:0]         command;
        logic [7:0]         order;
        logic signed [47:0] value;
        logic [5:0]         end_idx;
        logic               too_long;
    } t_line_result;

    t_line_result parsed_lines[$];

    logic [5:0]  byte_pos;
    logic [7:0]  command_hold;
    logic [7:0]  order_hold;
    logic        minus_seen;
    logic [5:0]  frac_start;
    logic [31:0] int_acc;
    logic [31:0] frac_acc;
    logic        acc_stopped;
    logic [5:0]  stop_pos;
    logic        overlong;
    int          fail_total = 0;
    int          pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic clear_line();
        byte_pos     = '0;
        command_hold = '0;
        order_hold   = '0;
        minus_seen   = 1'b0;
        frac_start   = '0;
        int_acc      = '0;
        frac_acc     = '0;
        acc_stopped  = 1'b0;
        stop_pos     = '0;
        overlong     = 1'b0;
    endtask

    // {keep going, new accumulator}
    function automatic logic [32:0] digit_accumulate(input logic [31:0] acc,
                                                     input logic [7:0] b);
        logic [31:0] scaled;
        if ($signed(acc) >= $signed(ACC_LIMIT_MUL)) begin
            return {1'b0, acc};
        end
        scaled = acc * 32'd10;
        if ($signed(scaled) >= $signed(ACC_LIMIT_ADD)) begin
            return {1'b0, scaled};
        end
        return {1'b1, scaled + {24'd0, b} - {24'd0, CHAR_ZERO}};
    endfunction

    function automatic logic [47:0] fixed_value(input logic [5:0] end_idx);
        longint          ip;
        longint          fp;
        longint          frac;
        longint          total;
        longint unsigned pow10;
        longint unsigned mag;
        int              e;
        ip   = $signed(int_acc);
        fp   = $signed(frac_acc);
        frac = 0;
        if (frac_start != 0 && end_idx >= frac_start) begin
            e = int'(end_idx) - int'(frac_start);
            if (e <= MAX_EXP) begin
                pow10 = 1;
                for (int k = 0; k < e; k++) begin
                    pow10 = pow10 * 10;
                end
                mag  = (fp < 0) ? -fp : fp;
                mag  = mag << FRAC_BITS;
                frac = longint'(mag / pow10);
                if (fp < 0) begin
                    frac = -frac;
                end
            end
        end
        total = ip * (longint'(1) << FRAC_BITS) + frac;
        if (minus_seen) begin
            total = -total;
        end
        if (total > VALUE_MAX) begin
            total = VALUE_MAX;
        end
        if (total < -VALUE_MAX) begin
            total = -VALUE_MAX;
        end
        return total[47:0];
    endfunction

    task automatic take_beat(input logic [7:0] b);
        logic [32:0]  acc_next;
        t_line_result r;
        if (b == CHAR_CR && byte_pos >= 2) begin
            r.end_idx  = acc_stopped ? stop_pos : byte_pos;
            r.command  = command_hold;
            r.order    = order_hold;
            r.value    = fixed_value(r.end_idx);
            r.too_long = overlong;
            parsed_lines.push_back(r);
            clear_line();
        end else if (byte_pos >= MAX_LINE) begin
            overlong = 1'b1;
        end else begin
            if (byte_pos == 0) begin
                command_hold = b;
            end else if (byte_pos == 1) begin
                order_hold = b;
            end else if (!acc_stopped) begin
                if (b == CHAR_MINUS) begin
                    minus_seen = 1'b1;
                end else if (b == CHAR_DOT) begin
                    frac_start = byte_pos + 6'd1;
                end else begin
                    if (frac_start == 0) begin
                        acc_next = digit_accumulate(int_acc, b);
                        int_acc  = acc_next[31:0];
                    end else begin
                        acc_next = digit_accumulate(frac_acc, b);
                        frac_acc = acc_next[31:0];
                    end
                    if (!acc_next[32]) begin
                        acc_stopped = 1'b1;
                        stop_pos    = byte_pos;
                    end
                end
            end
            byte_pos = byte_pos + 6'd1;
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_line_result r;
        if (!i_rst_n) begin
            clear_line();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (parsed_lines.size() == 0) begin
                    $error("result beat with nothing expected: command %0d order %0d",
                           i_command_byte, i_order_byte);
                    fail_total++;
                end else begin
                    r = parsed_lines.pop_front();
                    check_field("command_byte", r.command, i_command_byte);
                    check_field("order_byte", r.order, i_order_byte);
                    check_field("parsed_value", $signed(r.value), $signed(i_parsed_value));
                    check_field("end_index", r.end_idx, i_end_index);
                    check_field("line_too_long", r.too_long, i_line_too_long);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_beat(i_rx_byte);
            end
        end
        pending_total <= parsed_lines.size();
    end

endmodule

// File: tb/sv/ascii_command_decimal_parser_core_tb.sv
`timescale 1ns / 1ps

module ascii_command_decimal_parser_core_tb;
    import acdp_pkg::*;

    localparam int MAX_LINE    = MAX_LINE_DEF;
    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int ITEM_TARGET = 1550;
    localparam int DRAIN_WAIT  = 150;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_rx_byte = 8'd0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [7:0]         o_command_byte;
    logic [7:0]         o_order_byte;
    logic signed [47:0] o_parsed_value;
    logic [5:0]         o_end_index;
    logic               o_line_too_long;

    int         fail_count;
    int         pending;
    int         stall_left = 0;
    bit         quiet = 1'b0;
    int         items_sent = 0;
    logic [7:0] line_buf[$];

    always #4 i_clk = ~i_clk;

    ascii_command_decimal_parser_core #(
        .MAX_LINE (MAX_LINE),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command_byte (o_command_byte),
        .o_order_byte   (o_order_byte),
        .o_parsed_value (o_parsed_value),
        .o_end_index    (o_end_index),
        .o_line_too_long(o_line_too_long)
    );

    ascii_command_decimal_parser_checker #(
        .MAX_LINE (MAX_LINE),
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_command_byte (o_command_byte),
        .i_order_byte   (o_order_byte),
        .i_parsed_value (o_parsed_value),
        .i_end_index    (o_end_index),
        .i_line_too_long(o_line_too_long),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(0, 2);
        end else if (r < 93) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 2) == 0);
            stall_left  <= pause_len();
        end
    end

    function automatic logic [7:0] any_but_cr();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_CR) begin
            b = CHAR_ZERO;
        end
        return b;
    endfunction

    function automatic logic [7:0] digit_char();
        if ($urandom_range(0, 9) == 0) begin
            return any_but_cr();
        end
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] head_char();
        if ($urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    task automatic push_digits(input int n, input bit zeros);
        repeat (n) line_buf.push_back(zeros ? CHAR_ZERO : digit_char());
    endtask

    task automatic build_line();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 88) begin
            line_buf.push_back(head_char());
            line_buf.push_back(head_char());
            if (kind < 65) begin
                if ($urandom_range(0, 2) == 0) begin
                    line_buf.push_back(CHAR_MINUS);
                end
                push_digits($urandom_range(0, 7), 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    line_buf.push_back(CHAR_DOT);
                    push_digits($urandom_range(0, 8), 1'b0);
                end
                if ($urandom_range(0, 6) == 0) begin
                    line_buf.push_back(($urandom_range(0, 1) == 1) ? CHAR_MINUS : CHAR_DOT);
                    push_digits($urandom_range(0, 4), 1'b0);
                end
            end else if (kind < 77) begin
                // runs into the accumulator limit
                if ($urandom_range(0, 1) == 1) begin
                    line_buf.push_back(CHAR_MINUS);
                end
                if ($urandom_range(0, 1) == 1) begin
                    line_buf.push_back(CHAR_DOT);
                end
                push_digits($urandom_range(9, 14), 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    line_buf.push_back(CHAR_DOT);
                end
                push_digits($urandom_range(0, 4), 1'b0);
            end else if (kind < 83) begin
                // long zero fraction, 12 to 29 digits, up to past the largest power of ten
                line_buf.push_back(CHAR_DOT);
                push_digits($urandom_range(12, 29), 1'b1);
                if ($urandom_range(0, 1) == 1) begin
                    line_buf.push_back(digit_char());
                end
            end else begin
                push_digits($urandom_range(MAX_LINE - 1, MAX_LINE + 8), 1'b0);
            end
        end else if (kind < 95) begin
            repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 1)) line_buf.push_back(head_char());
        end
        line_buf.push_back(CHAR_CR);
    endtask

    task automatic put_byte(input logic [7:0] b);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_line();
        int gap;
        foreach (line_buf[k]) begin
            gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pause_len();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            put_byte(line_buf[k]);
            if (k < MAX_LINE || line_buf[k] == CHAR_CR) begin
                items_sent++;
            end
        end
        line_buf.delete();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int line_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // carriage return taken raw as command and order, then an empty value
        line_buf = '{CHAR_CR, CHAR_CR, CHAR_CR};
        send_line();
        // extreme head bytes, negative pure fraction
        line_buf = '{8'hFF, 8'h00, CHAR_MINUS, CHAR_DOT, 8'h35, CHAR_CR};
        send_line();
        // integer accumulator hits its limit
        line_buf = '{8'h61, 8'h62};
        push_digits(0, 1'b0);
        repeat (10) line_buf.push_back(8'h39);
        line_buf.push_back(CHAR_CR);
        send_line();
        wait_drained();

        line_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (line_no % 25 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            build_line();
            send_line();
            line_no++;
            if (line_no % 60 == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
